/* design/grb_pkg.sv */
package grb_pkg;

    localparam int MaxRows = 64;
    localparam int MaxCols = 64;
    localparam int RowW = 6;
    localparam int ColW = 6;
    localparam int IdxW = RowW + ColW;
    localparam int Cells = MaxRows * MaxCols;
    localparam int CntW = IdxW + 1;
    localparam int LimW = 7;

    localparam logic CfgRows = 1'b0;
    localparam logic KindLoad = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_CLR,
        ST_POP,
        ST_POPW,
        ST_NB,
        ST_NBW,
        ST_RES
    } state_t;

    // walker to map-ram requests
    typedef struct packed {
        logic             bm_we;
        logic [IdxW-1:0]  bm_waddr;
        logic             bm_wdata;
        logic [IdxW-1:0]  bm_raddr;
        logic             vm_we;
        logic [IdxW-1:0]  vm_waddr;
        logic             vm_wdata;
        logic [IdxW-1:0]  vm_raddr;
    } map_req_t;

    typedef struct packed {
        logic bm_rdata;
        logic vm_rdata;
    } map_rsp_t;

endpackage

/* design/grb_maps.sv */
module grb_maps (
    input  logic               aclk,
    input  grb_pkg::map_req_t  req,
    output grb_pkg::map_rsp_t  rsp
);
    logic blk_mem [grb_pkg::Cells];
    logic vis_mem [grb_pkg::Cells];
    logic blk_q_reg;
    logic vis_q_reg;

    always_ff @(posedge aclk) begin
        if (req.bm_we) begin
            blk_mem[req.bm_waddr] <= req.bm_wdata;
        end
        blk_q_reg <= blk_mem[req.bm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.vm_we) begin
            vis_mem[req.vm_waddr] <= req.vm_wdata;
        end
        vis_q_reg <= vis_mem[req.vm_raddr];
    end

    assign rsp.bm_rdata = blk_q_reg;
    assign rsp.vm_rdata = vis_q_reg;
endmodule

/* design/grb_fifo.sv */
module grb_fifo (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [grb_pkg::IdxW-1:0]   waddr,
    input  logic [grb_pkg::IdxW-1:0]   wdata,
    input  logic [grb_pkg::IdxW-1:0]   raddr,
    output logic [grb_pkg::IdxW-1:0]   rdata
);
    logic [grb_pkg::IdxW-1:0] mem [grb_pkg::Cells];
    logic [grb_pkg::IdxW-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        q_reg <= mem[raddr];
    end

    assign rdata = q_reg;
endmodule

/* design/grid_route_reachability.sv */
// Grid reachability engine.
// s_ channel: one beat per item, kind on s_tuser. kind 0 writes one cell of
// the wall map; kind 1 is a route query answered by a breadth-first walk over
// the cell map.
// m_ channel: one beat per query, route_found and bad_coordinate.
// cfg channel: index 0 rows_in_use, index 1 cols_in_use, taken any time.
// Query flow: a flagged endpoint goes straight to the result; otherwise the
// start and end wall words are read and a walled endpoint goes to the result;
// otherwise the visited map is swept (one entry a cycle through its single
// write port), then cells are popped from the frontier and their neighbours
// checked. The map and frontier memories have registered read ports.
// Reset (aresetn low, synchronous) clears the walker, returns the size
// registers to 64 and sweeps the wall map open with s_tready low. A stalled
// m_ beat holds; no new item is taken until the result has been taken.
module grid_route_reachability (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] kind
    input  logic        s_tuser,
    // [5:0] cell_row [11:6] cell_col [12] cell_blocked [18:13] start_row
    // [24:19] start_col [30:25] end_row [36:31] end_col
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] route_found [1] bad_coordinate
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    localparam int IW = grb_pkg::IdxW;
    localparam int CW = grb_pkg::CntW;

    grb_pkg::state_t state_reg, state_next;
    grb_pkg::map_req_t req;
    grb_pkg::map_rsp_t rsp;

    logic [6:0] rows_reg, cols_reg;
    logic [CW-1:0] clr_reg, clr_next;
    logic init_reg, init_next;
    logic [CW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [IW-1:0] s_reg, s_next, e_reg, e_next, cur_reg, cur_next;
    logic [1:0] nb_reg, nb_next;
    logic [IW-1:0] nbi_reg, nbi_next;
    logic found_reg, found_next, bad_reg, bad_next;
    logic mval_reg, mval_next;
    logic fifo_we;
    logic [IW-1:0] fifo_wdata, fifo_rdata;

    logic acc;
    logic [grb_pkg::RowW-1:0] sr, er, cr;
    logic [grb_pkg::ColW-1:0] sc, ec, cc;
    logic [6:0] nr, nc;
    logic nb_ok;
    logic [IW-1:0] nb_idx;

    assign cfg_ready = 1'b1;
    assign acc = s_tvalid && s_tready;
    assign s_tready = init_reg && (state_reg == grb_pkg::ST_IDLE) && !mval_reg;
    assign m_tvalid = mval_reg;
    assign m_tdata = {6'd0, bad_reg, found_reg};

    assign sr = s_tdata[18:13];
    assign sc = s_tdata[24:19];
    assign er = s_tdata[30:25];
    assign ec = s_tdata[36:31];
    assign nr = (rows_reg > 7'(grb_pkg::MaxRows)) ? 7'(grb_pkg::MaxRows) : rows_reg;
    assign nc = (cols_reg > 7'(grb_pkg::MaxCols)) ? 7'(grb_pkg::MaxCols) : cols_reg;
    assign cr = cur_reg[IW-1:grb_pkg::ColW];
    assign cc = cur_reg[grb_pkg::ColW-1:0];

    // neighbour order: up, left, right, down
    always_comb begin
        nb_ok = 1'b0;
        nb_idx = cur_reg;
        case (nb_reg)
            2'd0: begin
                nb_ok = (cr != '0);
                nb_idx = cur_reg - IW'(grb_pkg::MaxCols);
            end
            2'd1: begin
                nb_ok = (cc != '0);
                nb_idx = cur_reg - IW'(1);
            end
            2'd2: begin
                nb_ok = ({1'b0, cc} + 7'd1 < nc);
                nb_idx = cur_reg + IW'(1);
            end
            default: begin
                nb_ok = ({1'b0, cr} + 7'd1 < nr);
                nb_idx = cur_reg + IW'(grb_pkg::MaxCols);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 7'd64;
            cols_reg <= 7'd64;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == grb_pkg::CfgRows) begin
                rows_reg <= cfg_data;
            end else begin
                cols_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            grb_pkg::ST_IDLE: begin
                if (acc && s_tuser != grb_pkg::KindLoad) begin
                    if ({1'b0, sr} >= nr || {1'b0, sc} >= nc
                        || {1'b0, er} >= nr || {1'b0, ec} >= nc) begin
                        state_next = grb_pkg::ST_RES;
                    end else begin
                        state_next = grb_pkg::ST_CHK;
                    end
                end
            end
            grb_pkg::ST_CHK: begin
                // start word read last cycle; end word read now
                state_next = grb_pkg::ST_NBW;
            end
            grb_pkg::ST_CLR: begin
                if (clr_reg == CW'(grb_pkg::Cells - 1)) begin
                    state_next = grb_pkg::ST_POP;
                end
            end
            grb_pkg::ST_POP: begin
                state_next = (head_reg < tail_reg) ? grb_pkg::ST_POPW : grb_pkg::ST_RES;
            end
            grb_pkg::ST_POPW: begin
                state_next = (fifo_rdata == e_reg) ? grb_pkg::ST_RES : grb_pkg::ST_NB;
            end
            grb_pkg::ST_NB: begin
                if (nb_ok) begin
                    state_next = grb_pkg::ST_NBW;
                end else if (nb_reg == 2'd3) begin
                    state_next = grb_pkg::ST_POP;
                end
            end
            grb_pkg::ST_NBW: begin
                if (init_reg && clr_reg == CW'(grb_pkg::Cells)) begin
                    state_next = (rsp.bm_rdata || found_reg) ? grb_pkg::ST_RES
                                                             : grb_pkg::ST_CLR;
                end else begin
                    state_next = (nb_reg == 2'd3) ? grb_pkg::ST_POP : grb_pkg::ST_NB;
                end
            end
            grb_pkg::ST_RES: begin
                state_next = grb_pkg::ST_IDLE;
            end
            default: state_next = grb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        clr_next = clr_reg;
        init_next = init_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        s_next = s_reg;
        e_next = e_reg;
        cur_next = cur_reg;
        nb_next = nb_reg;
        nbi_next = nbi_reg;
        found_next = found_reg;
        bad_next = bad_reg;
        mval_next = mval_reg;
        fifo_we = 1'b0;
        fifo_wdata = s_reg;
        req = '0;
        req.bm_raddr = nbi_reg;
        req.vm_raddr = nbi_reg;
        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end
        if (!init_reg) begin
            // power-up sweep of the wall map
            req.bm_we = 1'b1;
            req.bm_waddr = clr_reg[IW-1:0];
            clr_next = clr_reg + CW'(1);
            if (clr_reg == CW'(grb_pkg::Cells - 1)) begin
                init_next = 1'b1;
            end
        end
        case (state_reg)
            grb_pkg::ST_IDLE: begin
                if (acc) begin
                    if (s_tuser == grb_pkg::KindLoad) begin
                        req.bm_we = 1'b1;
                        req.bm_waddr = {s_tdata[5:0], s_tdata[11:6]};
                        req.bm_wdata = s_tdata[12];
                    end else begin
                        s_next = {sr, sc};
                        e_next = {er, ec};
                        req.bm_raddr = {sr, sc};
                        found_next = 1'b0;
                        bad_next = 1'b1;
                        head_next = '0;
                        tail_next = '0;
                        // mark the sweep counter as the endpoint-check phase
                        clr_next = CW'(grb_pkg::Cells);
                    end
                end
            end
            grb_pkg::ST_CHK: begin
                bad_next = 1'b0;
                found_next = rsp.bm_rdata;
                req.bm_raddr = e_reg;
                nb_next = 2'd3;
            end
            grb_pkg::ST_CLR: begin
                req.vm_we = 1'b1;
                req.vm_waddr = clr_reg[IW-1:0];
                req.vm_wdata = (clr_reg[IW-1:0] == s_reg);
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(grb_pkg::Cells - 1)) begin
                    // clear the endpoint-check mark before the walk
                    clr_next = '0;
                    fifo_we = 1'b1;
                    fifo_wdata = s_reg;
                    head_next = '0;
                    tail_next = CW'(1);
                end
            end
            grb_pkg::ST_POP: begin
                if (head_reg >= tail_reg) begin
                    found_next = 1'b0;
                end
            end
            grb_pkg::ST_POPW: begin
                cur_next = fifo_rdata;
                head_next = head_reg + CW'(1);
                nb_next = 2'd0;
                if (fifo_rdata == e_reg) begin
                    found_next = 1'b1;
                end
            end
            grb_pkg::ST_NB: begin
                req.bm_raddr = nb_idx;
                req.vm_raddr = nb_idx;
                nbi_next = nb_idx;
                if (!nb_ok) begin
                    nb_next = nb_reg + 2'd1;
                end
            end
            grb_pkg::ST_NBW: begin
                if (init_reg && clr_reg == CW'(grb_pkg::Cells)) begin
                    found_next = found_reg || rsp.bm_rdata;
                    clr_next = '0;
                    if (rsp.bm_rdata || found_reg) begin
                        found_next = 1'b0;
                    end
                end else begin
                    if (!rsp.bm_rdata && !rsp.vm_rdata) begin
                        req.vm_we = 1'b1;
                        req.vm_waddr = nbi_reg;
                        req.vm_wdata = 1'b1;
                        if (tail_reg < CW'(grb_pkg::Cells)) begin
                            fifo_we = 1'b1;
                            fifo_wdata = nbi_reg;
                            tail_next = tail_reg + CW'(1);
                        end
                    end
                    nb_next = nb_reg + 2'd1;
                end
            end
            grb_pkg::ST_RES: begin
                mval_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= grb_pkg::ST_IDLE;
            clr_reg <= '0;
            init_reg <= 1'b0;
            head_reg <= '0;
            tail_reg <= '0;
            mval_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            init_reg <= init_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            mval_reg <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg <= s_next;
        e_reg <= e_next;
        cur_reg <= cur_next;
        nb_reg <= nb_next;
        nbi_reg <= nbi_next;
        found_reg <= found_next;
        bad_reg <= bad_next;
    end

    grb_maps u_maps (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    grb_fifo u_fifo (
        .aclk  (aclk),
        .we    (fifo_we),
        .waddr (tail_reg[IW-1:0]),
        .wdata (fifo_wdata),
        .raddr (head_reg[IW-1:0]),
        .rdata (fifo_rdata)
    );

    a_head_le_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg) else $error("frontier head passed tail");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mval_reg |-> !s_tready) else $error("item taken while result pending");
    a_res_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == grb_pkg::ST_RES |=> mval_reg) else $error("result lost");
    a_tail_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg <= CW'(grb_pkg::Cells)) else $error("frontier overflow");
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam logic KindQuery = 1'b1;
    localparam logic CfgCols = 1'b1;
    localparam int CycleLimit = 20000000;
    localparam int NumPhases = 8;
    localparam int PhaseItems = 165;

    typedef struct {
        bit         is_cfg;
        logic       cfg_idx;
        logic [6:0] cfg_val;
        logic       kind;
        logic [39:0] data;
        bit         typed;
        logic [1:0] exp;       // [0] route_found [1] bad_coordinate
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic        s_tuser;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [6:0]  cfg_data;

    // predictor state
    bit          wall_map [grb_pkg::Cells];
    bit          seen_map [grb_pkg::Cells];
    int          frontier [grb_pkg::Cells];
    logic [6:0]  rows_reg;
    logic [6:0]  cols_reg;

    logic [1:0]  route_q [$];
    stim_row_t   stim_tab [$];
    int          errors;
    int          cycles;
    int          tx_idle_pct;
    int          rx_stall_pct;

    grid_route_reachability u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [39:0] pack_load(int r, int c, bit blk);
        return {27'd0, blk, c[5:0], r[5:0]};
    endfunction

    function automatic logic [39:0] pack_query(int sr, int sc, int er, int ec);
        return {3'd0, ec[5:0], er[5:0], sc[5:0], sr[5:0], 13'd0};
    endfunction

    function automatic int used_rows();
        return (rows_reg < grb_pkg::MaxRows) ? int'(rows_reg) : grb_pkg::MaxRows;
    endfunction

    function automatic int used_cols();
        return (cols_reg < grb_pkg::MaxCols) ? int'(cols_reg) : grb_pkg::MaxCols;
    endfunction

    // breadth-first walk over the open cells; returns {bad, found}
    function automatic logic [1:0] predict_route(logic [39:0] d);
        int nr, nc, sr, sc, er, ec, s, e, head, tail, cur, r, c;
        nr = used_rows();
        nc = used_cols();
        sr = int'(d[18:13]);
        sc = int'(d[24:19]);
        er = int'(d[30:25]);
        ec = int'(d[36:31]);
        if (sr >= nr || sc >= nc || er >= nr || ec >= nc) return 2'b10;
        s = sr * grb_pkg::MaxCols + sc;
        e = er * grb_pkg::MaxCols + ec;
        if (wall_map[s] || wall_map[e]) return 2'b00;
        foreach (seen_map[i]) seen_map[i] = 1'b0;
        head = 0;
        tail = 1;
        frontier[0] = s;
        seen_map[s] = 1'b1;
        while (head < tail) begin
            cur = frontier[head];
            head++;
            if (cur == e) return 2'b01;
            r = cur / grb_pkg::MaxCols;
            c = cur % grb_pkg::MaxCols;
            for (int k = 0; k < 4; k++) begin
                int nb;
                bit ok;
                case (k)
                    0: begin ok = r > 0;      nb = cur - grb_pkg::MaxCols; end
                    1: begin ok = c > 0;      nb = cur - 1;       end
                    2: begin ok = c + 1 < nc; nb = cur + 1;       end
                    default: begin ok = r + 1 < nr; nb = cur + grb_pkg::MaxCols; end
                endcase
                if (ok && !wall_map[nb] && !seen_map[nb]) begin
                    seen_map[nb] = 1'b1;
                    if (tail < grb_pkg::Cells) begin
                        frontier[tail] = nb;
                        tail++;
                    end
                end
            end
        end
        return 2'b00;
    endfunction

    task automatic report_mismatch(string what, logic got, logic want);
        $display("mismatch %s: got %0b want %0b at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // send one item; on acceptance update the map or queue the expected answer
    task automatic send_item(logic kind, logic [39:0] d, bit typed, logic [1:0] want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        if (kind == grb_pkg::KindLoad)
            wall_map[int'(d[5:0]) * grb_pkg::MaxCols + int'(d[11:6])] = d[12];
        else
            route_q.push_back(typed ? want : predict_route(d));
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (route_q.size() == 0);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == grb_pkg::CfgRows) rows_reg = val;
        else cols_reg = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(bit is_cfg, logic idx, logic [6:0] val, logic kind,
                           logic [39:0] d, bit typed, logic [1:0] want);
        stim_row_t row;
        row.is_cfg  = is_cfg;
        row.cfg_idx = idx;
        row.cfg_val = val;
        row.kind    = kind;
        row.data    = d;
        row.typed   = typed;
        row.exp     = want;
        stim_tab.push_back(row);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        logic [1:0] want;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (route_q.size() == 0) begin
                $display("result beat with nothing pending, data %h", m_tdata);
                errors++;
            end else begin
                want = route_q.pop_front();
                if (m_tdata[0] !== want[0]) report_mismatch("route_found", m_tdata[0], want[0]);
                if (m_tdata[1] !== want[1])
                    report_mismatch("bad_coordinate", m_tdata[1], want[1]);
            end
        end
    end

    initial begin
        int rows_set [NumPhases] = '{2, 1, 127, 0, 64, 5, 9, 3};
        int cols_set [NumPhases] = '{3, 64, 1, 5, 64, 7, 4, 100};
        int nr, nc, qpct;
        logic kind;
        logic [39:0] d;

        errors       = 0;
        cycles       = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        s_tvalid     = 1'b0;
        s_tuser      = grb_pkg::KindLoad;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = grb_pkg::CfgRows;
        cfg_data     = '0;
        aresetn      = 1'b0;
        foreach (wall_map[i]) wall_map[i] = 1'b0;
        rows_reg = 7'd64;
        cols_reg = 7'd64;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows
        add_row(0, grb_pkg::CfgRows, 0, KindQuery, pack_query(0, 0, 0, 0), 1, 2'b01);
        add_row(0, grb_pkg::CfgRows, 0, grb_pkg::KindLoad, pack_load(63, 63, 1), 0, 0);
        add_row(0, grb_pkg::CfgRows, 0, KindQuery, pack_query(0, 0, 63, 63), 1, 2'b00);
        add_row(0, grb_pkg::CfgRows, 0, KindQuery, pack_query(63, 63, 0, 0), 1, 2'b00);
        add_row(0, grb_pkg::CfgRows, 0, grb_pkg::KindLoad, pack_load(63, 63, 0), 0, 0);
        add_row(0, grb_pkg::CfgRows, 0, KindQuery, pack_query(0, 0, 63, 63), 0, 0);
        add_row(1, grb_pkg::CfgRows, 7'd2, grb_pkg::KindLoad, '0, 0, 0);
        add_row(1, CfgCols, 7'd2, grb_pkg::KindLoad, '0, 0, 0);
        add_row(0, grb_pkg::CfgRows, 0, KindQuery, pack_query(0, 0, 2, 0), 1, 2'b10);
        add_row(0, grb_pkg::CfgRows, 0, KindQuery, pack_query(0, 0, 0, 2), 1, 2'b10);
        add_row(0, grb_pkg::CfgRows, 0, grb_pkg::KindLoad, pack_load(0, 1, 1), 0, 0);
        add_row(0, grb_pkg::CfgRows, 0, grb_pkg::KindLoad, pack_load(1, 0, 1), 0, 0);
        add_row(0, grb_pkg::CfgRows, 0, KindQuery, pack_query(0, 0, 1, 1), 0, 0);
        add_row(0, grb_pkg::CfgRows, 0, grb_pkg::KindLoad, pack_load(0, 1, 0), 0, 0);
        add_row(0, grb_pkg::CfgRows, 0, KindQuery, pack_query(0, 0, 1, 1), 0, 0);
        add_row(1, grb_pkg::CfgRows, 7'd0, grb_pkg::KindLoad, '0, 0, 0);
        add_row(0, grb_pkg::CfgRows, 0, KindQuery, pack_query(0, 0, 0, 0), 1, 2'b10);
        add_row(1, grb_pkg::CfgRows, 7'd127, grb_pkg::KindLoad, '0, 0, 0);
        add_row(1, CfgCols, 7'd1, grb_pkg::KindLoad, '0, 0, 0);
        add_row(0, grb_pkg::CfgRows, 0, KindQuery, pack_query(0, 0, 63, 0), 0, 0);
        add_row(0, grb_pkg::CfgRows, 0, KindQuery, pack_query(0, 0, 0, 1), 1, 2'b10);
        add_row(0, grb_pkg::CfgRows, 0, grb_pkg::KindLoad, pack_load(1, 0, 0), 0, 0);
        add_row(1, CfgCols, 7'd64, grb_pkg::KindLoad, '0, 0, 0);

        foreach (stim_tab[i]) begin
            if (stim_tab[i].is_cfg)
                write_reg(stim_tab[i].cfg_idx, stim_tab[i].cfg_val);
            else
                send_item(stim_tab[i].kind, stim_tab[i].data, stim_tab[i].typed,
                          stim_tab[i].exp);
        end

        for (int p = 0; p < NumPhases; p++) begin
            write_reg(grb_pkg::CfgRows, 7'(rows_set[p]));
            write_reg(CfgCols, 7'(cols_set[p]));
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
                default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
            endcase
            nr = used_rows();
            nc = used_cols();
            // a full-size open grid makes each walk long: keep queries rare there
            qpct = (nr * nc > 1024) ? 2 : 12;
            for (int n = 0; n < PhaseItems; n++) begin
                d = {3'b000, 5'($urandom()), 32'($urandom())};
                if ($urandom_range(0, 99) < qpct) begin
                    kind = KindQuery;
                    if (nr > 0 && nc > 0 && $urandom_range(0, 99) < 85) begin
                        d[18:13] = 6'($urandom_range(0, nr - 1));
                        d[24:19] = 6'($urandom_range(0, nc - 1));
                        d[30:25] = 6'($urandom_range(0, nr - 1));
                        d[36:31] = 6'($urandom_range(0, nc - 1));
                    end
                end else begin
                    kind = grb_pkg::KindLoad;
                    if (nr > 0 && nc > 0 && $urandom_range(0, 99) < 80) begin
                        d[5:0]  = 6'($urandom_range(0, nr - 1));
                        d[11:6] = 6'($urandom_range(0, nc - 1));
                        d[12]   = ($urandom_range(0, 99) < 30);
                    end
                end
                send_item(kind, d, 0, 0);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (route_q.size() == 0);
        repeat (16) @(posedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
design/grb_pkg.sv
design/grb_maps.sv
design/grb_fifo.sv
design/grid_route_reachability.sv
tb/sv/tb.sv
